// File: design/cfo_derotate_and_shift_macros.svh
// Assertion macros used by the checker file of the derotator.
`ifndef CFO_DEROTATE_AND_SHIFT_MACROS_SVH
`define CFO_DEROTATE_AND_SHIFT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CFODS_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset cycles included.
`define CFODS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/cfods_pkg.sv
// Package with the types, constants, sine table and helpers of the derotator.
package cfods_pkg;

  localparam int MAX_SHIFT    = 32;
  localparam int SINE_ENTRIES = 1024;

  localparam int PHASE_W     = 32;
  localparam int SAMPLE_W    = 16;
  localparam int SHIFT_W     = 7;
  localparam int BLK_W       = 6;
  localparam int IDX_W       = $clog2(SINE_ENTRIES);
  localparam int QTR_W       = IDX_W - 2;
  localparam int QTR_ENTRIES = SINE_ENTRIES / 4;
  localparam int ROM_AW      = QTR_W + 1;
  localparam int ROM_DW      = SAMPLE_W - 1;
  localparam int HOLD_DEPTH  = MAX_SHIFT;
  localparam int HOLD_AW     = (MAX_SHIFT > 1) ? $clog2(MAX_SHIFT) : 1;
  localparam int CNT_W       = $clog2(MAX_SHIFT + 1);
  localparam int PROD_W      = 2 * SAMPLE_W;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [CFG_AW-1:0] ADDR_PHASE_STEP   = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] ADDR_SAMPLE_SHIFT = CFG_AW'(4);
  localparam logic REG_SEL_PHASE_STEP   = 1'b0;
  localparam logic REG_SEL_SAMPLE_SHIFT = 1'b1;

  localparam logic signed [SHIFT_W-1:0] SHIFT_HI = SHIFT_W'(MAX_SHIFT);
  localparam logic signed [SHIFT_W-1:0] SHIFT_LO = -SHIFT_HI;

  localparam logic signed [SAMPLE_W+1:0] SAT_HI = (SAMPLE_W+2)'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [SAMPLE_W+1:0] SAT_LO = -(SAT_HI + (SAMPLE_W+2)'(1));

  typedef enum logic [2:0] {
    OP_PASS,
    OP_HOLD,
    OP_FLUSH,
    OP_DELAY_START,
    OP_DELAY,
    OP_ADVANCE,
    OP_ADVANCE_END
  } cfods_op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DATA,
    B_FLUSH,
    B_ZEROS,
    B_HELD
  } cfods_bstate_t;

  typedef struct packed {
    cfods_op_t          op;
    logic [HOLD_AW-1:0] addr;
    logic [CNT_W-1:0]   cnt;
    logic               last;
  } cfods_tag_t;

  typedef struct packed {
    cfods_tag_t          tag;
    logic [SAMPLE_W-1:0] im;
    logic [SAMPLE_W-1:0] re;
  } cfods_item_t;

  typedef logic [ROM_DW-1:0] qsine_rom_t [0:QTR_ENTRIES];

  function automatic longint mul_q30(longint a, longint unsigned b);
    longint unsigned m;
    longint unsigned prod;
    m = (a < 0) ? -a : a;
    prod = (m * b) >> 30;
    return (a < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic longint quarter_sine(longint unsigned t);
    longint unsigned t2;
    longint p;
    longint f;
    t2 = (t * t) >> 30;
    p = 172272;
    p = -5026995 + mul_q30(p, t2);
    p = 85569305 + mul_q30(p, t2);
    p = -693598668 + mul_q30(p, t2);
    p = 1686629713 + mul_q30(p, t2);
    f = mul_q30(p, t);
    if (f < 0) f = 0;
    f = (f + 16384) >>> 15;
    if (f > 32767) f = 32767;
    return f;
  endfunction

  function automatic qsine_rom_t build_qsine();
    qsine_rom_t rom;
    longint unsigned t;
    longint v;
    for (int i = 0; i <= QTR_ENTRIES; i++) begin
      t = longint'(i) << (30 - QTR_W);
      v = quarter_sine(t);
      rom[i] = ROM_DW'(v);
    end
    return rom;
  endfunction

  localparam qsine_rom_t QSINE_ROM = build_qsine();

  function automatic logic [SAMPLE_W-1:0] sat_sample(logic signed [SAMPLE_W+1:0] v);
    if (v > SAT_HI) return SAMPLE_W'(SAT_HI);
    if (v < SAT_LO) return SAMPLE_W'(SAT_LO);
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

// File: design/cfods_front.sv
// Front end: accepts samples, classifies them for the shift, and derotates them.
module cfods_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // in_real, in_imag
  input  logic                           in_tlast,   // in_end
  input  logic [cfods_pkg::PHASE_W-1:0]  phase_step,
  input  logic [cfods_pkg::SHIFT_W-1:0]  sample_shift,
  input  logic [cfods_pkg::QCNT_W-1:0]   q_count,
  output logic                           push,
  output cfods_pkg::cfods_item_t         push_item
);

  localparam int SW = cfods_pkg::SAMPLE_W;

  logic [cfods_pkg::PHASE_W-1:0] phase_acc_r, phase_acc_nxt;
  logic [cfods_pkg::BLK_W-1:0]   blk_cnt_r, blk_cnt_nxt;
  logic [cfods_pkg::HOLD_AW-1:0] hold_ptr_r, hold_ptr_nxt;
  logic                          flowing_r, flowing_nxt;
  logic signed [cfods_pkg::SHIFT_W-1:0] cur_shift_r, cur_shift_nxt;

  logic signed [cfods_pkg::SHIFT_W-1:0] shift_cfg, shift_sat, shift_eff;
  logic [cfods_pkg::CNT_W-1:0]          shift_mag;
  logic [cfods_pkg::CNT_W-1:0]          ptr_inc;
  logic                                 accept;
  cfods_pkg::cfods_tag_t                tag;

  logic [cfods_pkg::IDX_W-1:0]  idx;
  logic [cfods_pkg::QTR_W-1:0]  qtr_t;
  logic [cfods_pkg::ROM_AW-1:0] addr_fwd, addr_rev;

  logic                          a_valid_r;
  cfods_pkg::cfods_tag_t         a_tag_r;
  logic signed [SW-1:0]          a_re_r, a_im_r;
  logic [cfods_pkg::ROM_AW-1:0]  a_sin_addr_r, a_cos_addr_r;
  logic                          a_sin_neg_r, a_cos_neg_r;

  logic                          b_valid_r;
  cfods_pkg::cfods_tag_t         b_tag_r;
  logic signed [SW-1:0]          b_re_r, b_im_r, b_sin_r, b_cos_r;

  logic                          c_valid_r;
  cfods_pkg::cfods_tag_t         c_tag_r;
  logic signed [cfods_pkg::PROD_W-1:0] c_rc_r, c_is_r, c_rs_r, c_ic_r;

  logic signed [SW-1:0]          sin_val, cos_val;
  logic signed [cfods_pkg::PROD_W:0] yr_sum, yi_sum;
  logic signed [cfods_pkg::PROD_W:0] yr_rnd, yi_rnd;
  logic [cfods_pkg::QCNT_W:0]    in_flight;

  assign in_flight = (cfods_pkg::QCNT_W+1)'(q_count)
                   + (cfods_pkg::QCNT_W+1)'(a_valid_r)
                   + (cfods_pkg::QCNT_W+1)'(b_valid_r)
                   + (cfods_pkg::QCNT_W+1)'(c_valid_r);
  assign in_tready = in_flight < (cfods_pkg::QCNT_W+1)'(cfods_pkg::QUEUE_DEPTH);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    shift_cfg = $signed(sample_shift);
    if (shift_cfg > cfods_pkg::SHIFT_HI) begin
      shift_sat = cfods_pkg::SHIFT_HI;
    end else if (shift_cfg < cfods_pkg::SHIFT_LO) begin
      shift_sat = cfods_pkg::SHIFT_LO;
    end else begin
      shift_sat = shift_cfg;
    end
    shift_eff = (blk_cnt_r == '0 && !flowing_r) ? shift_sat : cur_shift_r;
    shift_mag = shift_eff[cfods_pkg::SHIFT_W-1] ? cfods_pkg::CNT_W'(-shift_eff)
                                                : cfods_pkg::CNT_W'(shift_eff);
    ptr_inc = cfods_pkg::CNT_W'(hold_ptr_r) + cfods_pkg::CNT_W'(1);

    tag           = '0;
    tag.op        = cfods_pkg::OP_PASS;
    tag.last      = in_tlast;
    cur_shift_nxt = shift_eff;
    flowing_nxt   = flowing_r;
    hold_ptr_nxt  = hold_ptr_r;

    if (shift_mag == '0) begin
      tag.op = cfods_pkg::OP_PASS;
    end else if (!flowing_r && blk_cnt_r < cfods_pkg::BLK_W'(shift_mag)) begin
      if (in_tlast) begin
        tag.op  = cfods_pkg::OP_FLUSH;
        tag.cnt = cfods_pkg::CNT_W'(blk_cnt_r);
      end else begin
        tag.op   = cfods_pkg::OP_HOLD;
        tag.addr = cfods_pkg::HOLD_AW'(blk_cnt_r);
      end
    end else if (!shift_eff[cfods_pkg::SHIFT_W-1]) begin
      tag.op       = flowing_r ? cfods_pkg::OP_DELAY : cfods_pkg::OP_DELAY_START;
      tag.addr     = hold_ptr_r;
      tag.cnt      = shift_mag;
      flowing_nxt  = 1'b1;
      hold_ptr_nxt = (ptr_inc == shift_mag) ? '0 : cfods_pkg::HOLD_AW'(ptr_inc);
    end else begin
      tag.op      = in_tlast ? cfods_pkg::OP_ADVANCE_END : cfods_pkg::OP_ADVANCE;
      tag.cnt     = shift_mag;
      flowing_nxt = 1'b1;
    end

    if (in_tlast) begin
      phase_acc_nxt = '0;
      blk_cnt_nxt   = '0;
      hold_ptr_nxt  = '0;
      flowing_nxt   = 1'b0;
    end else begin
      phase_acc_nxt = phase_acc_r + phase_step;
      blk_cnt_nxt   = (blk_cnt_r == '1) ? blk_cnt_r : blk_cnt_r + 1'b1;
    end
  end

  assign idx      = phase_acc_r[cfods_pkg::PHASE_W-1 -: cfods_pkg::IDX_W];
  assign qtr_t    = idx[cfods_pkg::QTR_W-1:0];
  assign addr_fwd = {1'b0, qtr_t};
  assign addr_rev = cfods_pkg::ROM_AW'(cfods_pkg::QTR_ENTRIES) - addr_fwd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      blk_cnt_r   <= '0;
      hold_ptr_r  <= '0;
      flowing_r   <= 1'b0;
      cur_shift_r <= '0;
    end else if (accept) begin
      phase_acc_r <= phase_acc_nxt;
      blk_cnt_r   <= blk_cnt_nxt;
      hold_ptr_r  <= hold_ptr_nxt;
      flowing_r   <= flowing_nxt;
      cur_shift_r <= cur_shift_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
  end

  assign sin_val = a_sin_neg_r ? -$signed({1'b0, cfods_pkg::QSINE_ROM[a_sin_addr_r]})
                               :  $signed({1'b0, cfods_pkg::QSINE_ROM[a_sin_addr_r]});
  assign cos_val = a_cos_neg_r ? -$signed({1'b0, cfods_pkg::QSINE_ROM[a_cos_addr_r]})
                               :  $signed({1'b0, cfods_pkg::QSINE_ROM[a_cos_addr_r]});

  always_ff @(posedge clk) begin
    a_tag_r      <= tag;
    a_re_r       <= $signed(in_tdata[SW-1:0]);
    a_im_r       <= $signed(in_tdata[2*SW-1:SW]);
    a_sin_addr_r <= idx[cfods_pkg::IDX_W-2] ? addr_rev : addr_fwd;
    a_cos_addr_r <= idx[cfods_pkg::IDX_W-2] ? addr_fwd : addr_rev;
    a_sin_neg_r  <= idx[cfods_pkg::IDX_W-1];
    a_cos_neg_r  <= idx[cfods_pkg::IDX_W-1] ^ idx[cfods_pkg::IDX_W-2];

    b_tag_r <= a_tag_r;
    b_re_r  <= a_re_r;
    b_im_r  <= a_im_r;
    b_sin_r <= sin_val;
    b_cos_r <= cos_val;

    c_tag_r <= b_tag_r;
    c_rc_r  <= b_re_r * b_cos_r;
    c_is_r  <= b_im_r * b_sin_r;
    c_rs_r  <= b_re_r * b_sin_r;
    c_ic_r  <= b_im_r * b_cos_r;
  end

  assign yr_sum = (cfods_pkg::PROD_W+1)'(c_rc_r) - (cfods_pkg::PROD_W+1)'(c_is_r);
  assign yi_sum = (cfods_pkg::PROD_W+1)'(c_rs_r) + (cfods_pkg::PROD_W+1)'(c_ic_r);
  assign yr_rnd = yr_sum + (cfods_pkg::PROD_W+1)'(2 ** (SW - 2));
  assign yi_rnd = yi_sum + (cfods_pkg::PROD_W+1)'(2 ** (SW - 2));

  assign push         = c_valid_r;
  assign push_item.tag = c_tag_r;
  assign push_item.re  = cfods_pkg::sat_sample(yr_rnd[cfods_pkg::PROD_W -: SW+2]);
  assign push_item.im  = cfods_pkg::sat_sample(yi_rnd[cfods_pkg::PROD_W -: SW+2]);

endmodule

// File: design/cfods_queue.sv
// Small queue that decouples the derotating front end from the shift back end.
module cfods_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  cfods_pkg::cfods_item_t       push_item,
  input  logic                         pop,
  output cfods_pkg::cfods_item_t       head,
  output logic                         head_valid,
  output logic [cfods_pkg::QCNT_W-1:0] count
);

  cfods_pkg::cfods_item_t slots [cfods_pkg::QUEUE_DEPTH];
  logic [cfods_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [cfods_pkg::QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head       = slots[rd_ptr_r];
  assign head_valid = count_r != '0;
  assign count      = count_r;

endmodule

// File: design/cfods_back.sv
// Back end: applies the sample shift with the hold memory and drives the result beats.
module cfods_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfods_pkg::cfods_item_t head,
  input  logic                   head_valid,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata,  // out_real, out_imag
  output logic                   out_tlast   // out_end
);

  localparam int DW = 2 * cfods_pkg::SAMPLE_W;

  cfods_pkg::cfods_bstate_t state_r, state_nxt;
  cfods_pkg::cfods_item_t   cur_r, cur_nxt;
  logic [cfods_pkg::CNT_W-1:0]   idx_r, idx_nxt, idx_inc;

  logic [DW-1:0] hold_mem [cfods_pkg::HOLD_DEPTH];
  logic [DW-1:0] rdata_r;
  logic [cfods_pkg::HOLD_AW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] wr_data;
  logic          wr_en;

  logic          out_valid_r;
  logic [DW-1:0] out_data_r;
  logic          out_last_r;
  logic          can_emit, emit, emit_last;
  logic [DW-1:0] emit_data;

  assign can_emit = !out_valid_r || out_tready;
  assign idx_inc  = idx_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    idx_nxt   = idx_r;
    pop       = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    emit_last = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = cur_r.tag.addr;
    wr_data   = {cur_r.im, cur_r.re};
    rd_addr   = cur_r.tag.addr;

    unique case (state_r)
      cfods_pkg::B_IDLE: begin
        rd_addr = (head.tag.op == cfods_pkg::OP_FLUSH) ? '0 : head.tag.addr;
        if (head_valid) begin
          unique case (head.tag.op) inside
            cfods_pkg::OP_PASS, cfods_pkg::OP_ADVANCE: begin
              if (can_emit) begin
                pop       = 1'b1;
                emit      = 1'b1;
                emit_data = {head.im, head.re};
                emit_last = head.tag.last;
              end
            end
            cfods_pkg::OP_HOLD: begin
              pop     = 1'b1;
              wr_en   = 1'b1;
              wr_addr = head.tag.addr;
              wr_data = {head.im, head.re};
            end
            cfods_pkg::OP_FLUSH: begin
              pop       = 1'b1;
              cur_nxt   = head;
              idx_nxt   = '0;
              state_nxt = (head.tag.cnt == '0) ? cfods_pkg::B_DATA : cfods_pkg::B_FLUSH;
            end
            cfods_pkg::OP_DELAY_START: begin
              pop       = 1'b1;
              cur_nxt   = head;
              idx_nxt   = '0;
              state_nxt = cfods_pkg::B_ZEROS;
            end
            cfods_pkg::OP_DELAY: begin
              pop       = 1'b1;
              cur_nxt   = head;
              state_nxt = cfods_pkg::B_HELD;
            end
            cfods_pkg::OP_ADVANCE_END: begin
              pop       = 1'b1;
              cur_nxt   = head;
              idx_nxt   = '0;
              state_nxt = cfods_pkg::B_DATA;
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      cfods_pkg::B_DATA: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_data = {cur_r.im, cur_r.re};
          emit_last = cur_r.tag.last && (cur_r.tag.op != cfods_pkg::OP_ADVANCE_END);
          state_nxt = (cur_r.tag.op == cfods_pkg::OP_ADVANCE_END) ? cfods_pkg::B_ZEROS
                                                                  : cfods_pkg::B_IDLE;
        end
      end
      cfods_pkg::B_FLUSH: begin
        rd_addr = cfods_pkg::HOLD_AW'(idx_r);
        if (can_emit) begin
          emit      = 1'b1;
          emit_data = rdata_r;
          rd_addr   = cfods_pkg::HOLD_AW'(idx_inc);
          idx_nxt   = idx_inc;
          if (idx_inc == cur_r.tag.cnt) state_nxt = cfods_pkg::B_DATA;
        end
      end
      cfods_pkg::B_ZEROS: begin
        if (can_emit) begin
          emit    = 1'b1;
          idx_nxt = idx_inc;
          if (idx_inc == cur_r.tag.cnt) begin
            if (cur_r.tag.op == cfods_pkg::OP_ADVANCE_END) begin
              emit_last = 1'b1;
              state_nxt = cfods_pkg::B_IDLE;
            end else begin
              state_nxt = cfods_pkg::B_HELD;
            end
          end
        end
      end
      cfods_pkg::B_HELD: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_data = rdata_r;
          emit_last = cur_r.tag.last;
          wr_en     = 1'b1;
          state_nxt = cfods_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = cfods_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) hold_mem[wr_addr] <= wr_data;
    rdata_r <= hold_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfods_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    if (emit) begin
      out_data_r <= emit_data;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: design/cfo_derotate_and_shift.sv
// Unless held back, an accepted beat passes front-end stages a, b and c, the queue and
// the output register. Throughput, output not stalled: one beat per cycle with zero or
// negative shift; with a positive shift a delayed sample passes the idle and held states
// for the hold memory read and write, zero runs leave at one beat per cycle; the input stalls
// once the queue and three pipeline stages hold eight beats. Reset: synchronous, active
// low; clears control registers, phase and block state, not data registers or hold memory.
module cfo_derotate_and_shift (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // in_real, in_imag
  input  logic        in_tlast,   // in_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_real, out_imag
  output logic        out_tlast,  // out_end
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [cfods_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [cfods_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [cfods_pkg::CFG_DW-1:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [cfods_pkg::PHASE_W-1:0] phase_step_r;
  logic [cfods_pkg::SHIFT_W-1:0] sample_shift_r;
  logic                          cfg_wr;

  logic                         push, pop, head_valid;
  cfods_pkg::cfods_item_t       push_item, head;
  logic [cfods_pkg::QCNT_W-1:0] q_count;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= '0;
      sample_shift_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[cfods_pkg::CFG_AW-1])
        cfods_pkg::REG_SEL_PHASE_STEP:   phase_step_r <= cfg_pwdata[cfods_pkg::PHASE_W-1:0];
        cfods_pkg::REG_SEL_SAMPLE_SHIFT: sample_shift_r <= cfg_pwdata[cfods_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[cfods_pkg::CFG_AW-1])
      cfods_pkg::REG_SEL_PHASE_STEP:   cfg_prdata = cfods_pkg::CFG_DW'(phase_step_r);
      cfods_pkg::REG_SEL_SAMPLE_SHIFT: cfg_prdata = cfods_pkg::CFG_DW'(sample_shift_r);
      default:                         cfg_prdata = '0;
    endcase
  end

  cfods_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .phase_step   (phase_step_r),
    .sample_shift (sample_shift_r),
    .q_count      (q_count),
    .push         (push),
    .push_item    (push_item)
  );

  cfods_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (q_count)
  );

  cfods_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: design/cfods_checker.sv
// Port-level checker for the derotator and its bind to the top level.
`include "cfo_derotate_and_shift_macros.svh"

module cfods_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [cfods_pkg::CFG_AW-1:0] cfg_paddr,
  input logic [cfods_pkg::CFG_DW-1:0] cfg_pwdata,
  input logic [cfods_pkg::CFG_DW-1:0] cfg_prdata,
  input logic        cfg_pready
);

  // A reset cycle leaves no result beat pending.
  `CFODS_ASSERT_ALWAYS(a_reset_out_idle, (!rst_n |=> !out_tvalid), "result beat after reset")

  // After reset the pipeline and queue are empty, so a sample is taken at once.
  `CFODS_ASSERT_ALWAYS(a_reset_in_ready, (!rst_n |=> in_tready), "input not ready after reset")

  // A stalled result beat keeps its contents.
  `CFODS_ASSERT_ON(a_out_hold, (out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)), "stalled result beat changed")

  // A phase step write reads back on the following cycle.
  `CFODS_ASSERT_ON(a_step_readback, ((cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == cfods_pkg::ADDR_PHASE_STEP) ##1 (cfg_paddr == cfods_pkg::ADDR_PHASE_STEP) |-> cfg_prdata == $past(cfg_pwdata)), "phase step readback mismatch")

endmodule

bind cfo_derotate_and_shift cfods_checker u_cfods_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tlast   (out_tlast),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata),
  .cfg_pready  (cfg_pready)
);
